>>> hdl/apsp_pkg.sv
`default_nettype none

package apsp_pkg;

    // Sizing
    localparam int MAX_VERTICES        = 8;
    localparam int WEIGHT_BITS         = 16;
    localparam int VERTEX_W            = 3;
    localparam int ACTION_W            = 2;
    localparam int IN_WEIGHT_W         = 16;
    localparam int COUNT_W             = 4;
    localparam int DIST_OUT_W          = 19;
    localparam int VERTEX_COUNT_RESET  = 8;

    // Stored weights never exceed the input field
    localparam int STORED_W     = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
    // A shortest cycle holds at most MAX_VERTICES weights, which VERTEX_W extra bits cover; one more bit is spare
    localparam int DIST_W       = STORED_W + VERTEX_W + 1;
    localparam int CELL_W       = 2 * VERTEX_W;
    localparam int CELLS        = 1 << CELL_W;
    localparam int EDGE_ENTRY_W = STORED_W + 1;
    localparam int PATH_ENTRY_W = 1 + DIST_W + VERTEX_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_SOLVE = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_EDGE_WRITE,
        OP_CLEAR,
        OP_INIT_READ,
        OP_INIT_WRITE,
        OP_RELAX_READ_A,
        OP_RELAX_READ_B,
        OP_RELAX_UPDATE,
        OP_EMIT_READ,
        OP_EMIT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [VERTEX_W-1:0] k;
        logic [VERTEX_W-1:0] i;
        logic [VERTEX_W-1:0] j;
        logic                last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic                absent;
        logic [STORED_W-1:0] weight;
    } edge_entry_t;

    typedef struct packed {
        logic                inf;
        logic [DIST_W-1:0]   path_len;
        logic [VERTEX_W-1:0] pred;
    } path_entry_t;

endpackage

`default_nettype wire

>>> hdl/apsp_ram.sv
`default_nettype none

module apsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/apsp_ctrl.sv
`default_nettype none

module apsp_ctrl
    import apsp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [VERTEX_W-1:0] from_vertex,
    input  wire logic [VERTEX_W-1:0] to_vertex,
    output logic                     in_stall,
    input  wire logic                cfg_valid,
    input  wire logic [COUNT_W-1:0]  cfg_data,
    output logic                     cfg_ready,
    input  wire dp_status_t          status,
    output dp_cmd_t                  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_INIT_RD = 8'b0000_0010,
        ST_INIT_WR = 8'b0000_0100,
        ST_RLX_RD1 = 8'b0000_1000,
        ST_RLX_RD2 = 8'b0001_0000,
        ST_RLX_UPD = 8'b0010_0000,
        ST_EMIT_RD = 8'b0100_0000,
        ST_EMIT_OUT = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [VERTEX_W-1:0] k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [COUNT_W-1:0]  vertex_count_reg, vertex_count_next;
    logic [COUNT_W-1:0]  used;
    logic [VERTEX_W-1:0] last_idx;
    logic                i_wrap, j_wrap, k_wrap;
    logic                write_in_range;

    // Clamp the vertex count to 1..MAX_VERTICES
    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            used = COUNT_W'(1);
        end
        else if (vertex_count_reg > COUNT_W'(MAX_VERTICES))
        begin
            used = COUNT_W'(MAX_VERTICES);
        end
        else
        begin
            used = vertex_count_reg;
        end
        last_idx = VERTEX_W'(used - COUNT_W'(1));
    end

    assign i_wrap = (i_reg == last_idx);
    assign j_wrap = (j_reg == last_idx);
    assign k_wrap = (k_reg == last_idx);

    assign write_in_range = ({1'b0, from_vertex} < (VERTEX_W + 1)'(MAX_VERTICES))
                         && ({1'b0, to_vertex} < (VERTEX_W + 1)'(MAX_VERTICES));

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        vertex_count_next = vertex_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            vertex_count_next = cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd.op     = OP_NONE;
        cmd.k      = k_reg;
        cmd.i      = i_reg;
        cmd.j      = j_reg;
        cmd.last   = i_wrap && j_wrap;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_WRITE)
                    begin
                        cmd.op = write_in_range ? OP_EDGE_WRITE : OP_NONE;
                    end
                    else if (action == ACT_CLEAR)
                    begin
                        cmd.op = OP_CLEAR;
                    end
                    else if (action == ACT_SOLVE)
                    begin
                        k_next     = '0;
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_INIT_RD;
                    end
                end
            end
            ST_INIT_RD:
            begin
                cmd.op     = OP_INIT_READ;
                state_next = ST_INIT_WR;
            end
            ST_INIT_WR:
            begin
                cmd.op = OP_INIT_WRITE;
                if (j_wrap)
                begin
                    j_next = '0;
                    i_next = i_wrap ? '0 : i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
                state_next = (i_wrap && j_wrap) ? ST_RLX_RD1 : ST_INIT_RD;
            end
            ST_RLX_RD1:
            begin
                cmd.op     = OP_RELAX_READ_A;
                state_next = ST_RLX_RD2;
            end
            ST_RLX_RD2:
            begin
                cmd.op     = OP_RELAX_READ_B;
                state_next = ST_RLX_UPD;
            end
            ST_RLX_UPD:
            begin
                cmd.op = OP_RELAX_UPDATE;
                if (j_wrap)
                begin
                    j_next = '0;
                    if (i_wrap)
                    begin
                        i_next = '0;
                        k_next = k_wrap ? '0 : k_reg + 1'b1;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
                state_next = (k_wrap && i_wrap && j_wrap) ? ST_EMIT_RD : ST_RLX_RD1;
            end
            ST_EMIT_RD:
            begin
                cmd.op     = OP_EMIT_READ;
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_EMIT_LOAD;
                    if (j_wrap)
                    begin
                        j_next = '0;
                        i_next = i_wrap ? '0 : i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    state_next = (i_wrap && j_wrap) ? ST_IDLE : ST_EMIT_RD;
                end
                else
                begin
                    // Hold the read address so the read data stays put
                    cmd.op = OP_EMIT_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            k_reg            <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            vertex_count_reg <= COUNT_W'(VERTEX_COUNT_RESET);
        end
        else
        begin
            state_reg        <= state_next;
            k_reg            <= k_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            vertex_count_reg <= vertex_count_next;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (k_reg <= last_idx && i_reg <= last_idx && j_reg <= last_idx))
        else $error("loop index beyond vertex count");

    a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action == ACT_SOLVE) |=> (state_reg == ST_INIT_RD))
        else $error("solve transaction did not start initialization");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_OUT && !status.out_free) |=> (state_reg == ST_EMIT_OUT))
        else $error("emission advanced while output register was occupied");

endmodule

`default_nettype wire

>>> hdl/apsp_datapath.sv
`default_nettype none

module apsp_datapath
    import apsp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dp_cmd_t                cmd,
    input  wire logic [VERTEX_W-1:0]    from_vertex,
    input  wire logic [VERTEX_W-1:0]    to_vertex,
    input  wire logic [IN_WEIGHT_W-1:0] edge_weight,
    input  wire logic                   no_edge,
    input  wire logic                   out_stall,
    output dp_status_t                  status,
    output logic                        out_valid,
    output logic [VERTEX_W-1:0]         pair_source,
    output logic [VERTEX_W-1:0]         pair_destination,
    output logic [DIST_OUT_W-1:0]       distance,
    output logic                        unreachable,
    output logic [VERTEX_W-1:0]         predecessor,
    output logic                        last_pair
);

    logic [CELL_W-1:0] cell_ij, cell_ik, cell_kj, cell_wr;

    assign cell_ij = {cmd.i, cmd.j};
    assign cell_ik = {cmd.i, cmd.k};
    assign cell_kj = {cmd.k, cmd.j};
    assign cell_wr = {from_vertex, to_vertex};

    // Edge store: RAM plus one valid bit per entry; an entry never written since
    // reset or the last clear reads as no-edge, or zero on the diagonal.
    edge_entry_t edge_wdata, edge_rdata, edge_init;
    logic [CELLS-1:0] edge_vld_reg, edge_vld_next;
    logic edge_vld_q_reg, diag_q_reg;

    assign edge_wdata.absent = no_edge;
    assign edge_wdata.weight = edge_weight[STORED_W-1:0];

    apsp_ram #(
        .WIDTH (EDGE_ENTRY_W),
        .DEPTH (CELLS)
    ) u_edge_ram (
        .clk   (clk),
        .we    (cmd.op == OP_EDGE_WRITE),
        .waddr (cell_wr),
        .wdata (edge_wdata),
        .raddr (cell_ij),
        .rdata (edge_rdata)
    );

    always_comb
    begin
        edge_vld_next = edge_vld_reg;
        if (cmd.op == OP_CLEAR)
        begin
            edge_vld_next = '0;
        end
        if (cmd.op == OP_EDGE_WRITE)
        begin
            edge_vld_next[cell_wr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_vld_reg <= '0;
        end
        else
        begin
            edge_vld_reg <= edge_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_vld_q_reg <= edge_vld_reg[cell_ij];
        diag_q_reg     <= (cmd.i == cmd.j);
    end

    always_comb
    begin
        if (edge_vld_q_reg)
        begin
            edge_init = edge_rdata;
        end
        else
        begin
            edge_init.absent = !diag_q_reg;
            edge_init.weight = '0;
        end
    end

    // Path store: two copies written together give two read ports
    path_entry_t path_wdata, rdata_a, rdata_b;
    path_entry_t ik_reg, kj_reg;
    logic [CELL_W-1:0] raddr_a;
    logic [DIST_W:0] sum;
    logic win, path_we;

    assign raddr_a = (cmd.op == OP_RELAX_READ_A) ? cell_ik : cell_ij;

    apsp_ram #(
        .WIDTH (PATH_ENTRY_W),
        .DEPTH (CELLS)
    ) u_path_ram_a (
        .clk   (clk),
        .we    (path_we),
        .waddr (cell_ij),
        .wdata (path_wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    apsp_ram #(
        .WIDTH (PATH_ENTRY_W),
        .DEPTH (CELLS)
    ) u_path_ram_b (
        .clk   (clk),
        .we    (path_we),
        .waddr (cell_ij),
        .wdata (path_wdata),
        .raddr (cell_kj),
        .rdata (rdata_b)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_RELAX_READ_B)
        begin
            ik_reg <= rdata_a;
            kj_reg <= rdata_b;
        end
    end

    // Strict improvement only; any infinite leg loses
    assign sum = {1'b0, ik_reg.path_len} + {1'b0, kj_reg.path_len};
    assign win = !ik_reg.inf && !kj_reg.inf
              && (rdata_a.inf || (sum < {1'b0, rdata_a.path_len}));

    always_comb
    begin
        path_we = 1'b0;
        path_wdata.inf      = edge_init.absent;
        path_wdata.path_len = DIST_W'(edge_init.weight);
        path_wdata.pred     = cmd.i;
        if (cmd.op == OP_INIT_WRITE)
        begin
            path_we = 1'b1;
        end
        else if (cmd.op == OP_RELAX_UPDATE && win)
        begin
            path_we             = 1'b1;
            path_wdata.inf      = 1'b0;
            path_wdata.path_len = sum[DIST_W-1:0];
            path_wdata.pred     = kj_reg.pred;
        end
    end

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [VERTEX_W-1:0]   src_reg, dst_reg, pred_reg;
    logic [DIST_OUT_W-1:0] dist_reg;
    logic                  unreach_reg, last_reg;
    logic                  load;

    assign status.out_free = !out_valid_reg || !out_stall;
    assign load = (cmd.op == OP_EMIT_LOAD);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            src_reg     <= cmd.i;
            dst_reg     <= cmd.j;
            dist_reg    <= rdata_a.inf ? '0 : DIST_OUT_W'(rdata_a.path_len);
            unreach_reg <= rdata_a.inf;
            pred_reg    <= rdata_a.pred;
            last_reg    <= cmd.last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pair_source      = src_reg;
    assign pair_destination = dst_reg;
    assign distance         = dist_reg;
    assign unreachable      = unreach_reg;
    assign predecessor      = pred_reg;
    assign last_pair        = last_reg;

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && unreach_reg) |-> (dist_reg == '0))
        else $error("unreachable pair carries a nonzero distance");

endmodule

`default_nettype wire

>>> hdl/all_pairs_shortest_path.sv
// Edge write and clear transactions are accepted back to back.
// A solve stalls the input through initialization (a read and a write per cell),
// relaxation (one path-store read pair, one read, one update per step) and
// emission (a read and a load per pair), plus any output stall.
// Reset (async, active low) marks every edge no-edge with a zero diagonal,
// sets vertex_count to 8 and empties the output register.
`default_nettype none

module all_pairs_shortest_path
    import apsp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // Input transaction: edge write, graph clear or solve
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [ACTION_W-1:0]    action,
    input  wire logic [VERTEX_W-1:0]    from_vertex,
    input  wire logic [VERTEX_W-1:0]    to_vertex,
    input  wire logic [IN_WEIGHT_W-1:0] edge_weight,
    input  wire logic                   no_edge,

    // Result transaction: one per vertex pair, row-major
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [VERTEX_W-1:0]         pair_source,
    output logic [VERTEX_W-1:0]         pair_destination,
    output logic [DIST_OUT_W-1:0]       distance,
    output logic                        unreachable,
    output logic [VERTEX_W-1:0]         predecessor,
    output logic                        last_pair,

    // vertex_count register write
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [COUNT_W-1:0]     cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Controller: sequences initialization, the k/i/j relaxation sweep and
    // emission; owns the vertex count register.
    apsp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .action      (action),
        .from_vertex (from_vertex),
        .to_vertex   (to_vertex),
        .in_stall    (in_stall),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .cfg_ready   (cfg_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Datapath: edge store, duplicated path store, relaxation adder and
    // comparator, output register.
    apsp_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .from_vertex      (from_vertex),
        .to_vertex        (to_vertex),
        .edge_weight      (edge_weight),
        .no_edge          (no_edge),
        .out_stall        (out_stall),
        .status           (status),
        .out_valid        (out_valid),
        .pair_source      (pair_source),
        .pair_destination (pair_destination),
        .distance         (distance),
        .unreachable      (unreachable),
        .predecessor      (predecessor),
        .last_pair        (last_pair)
    );

endmodule

`default_nettype wire

>>> tb/apsp_path_checker.sv
module apsp_path_checker
    import apsp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [ACTION_W-1:0]    action,
    input  wire logic [VERTEX_W-1:0]    from_vertex,
    input  wire logic [VERTEX_W-1:0]    to_vertex,
    input  wire logic [IN_WEIGHT_W-1:0] edge_weight,
    input  wire logic                   no_edge,

    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic [VERTEX_W-1:0]    pair_source,
    input  wire logic [VERTEX_W-1:0]    pair_destination,
    input  wire logic [DIST_OUT_W-1:0]  distance,
    input  wire logic                   unreachable,
    input  wire logic [VERTEX_W-1:0]    predecessor,
    input  wire logic                   last_pair,

    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [COUNT_W-1:0]     cfg_data,

    output int                          mismatch_total,
    output int                          results_outstanding
);

    typedef struct packed {
        logic [VERTEX_W-1:0]   src_v;
        logic [VERTEX_W-1:0]   dst_v;
        logic [DIST_OUT_W-1:0] length;
        logic                  unreach;
        logic [VERTEX_W-1:0]   pred;
        logic                  last;
    } pair_result_t;

    logic [STORED_W-1:0] edge_len [CELLS];
    logic                edge_gone [CELLS];
    logic [COUNT_W-1:0]  count_setting;
    pair_result_t        expected_pairs [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_total++;
    endtask

    function automatic void clear_edges();
        for (int i = 0; i < MAX_VERTICES; i++)
            for (int j = 0; j < MAX_VERTICES; j++)
            begin
                edge_len[i * MAX_VERTICES + j] = '0;
                edge_gone[i * MAX_VERTICES + j] = (i != j);
            end
    endfunction

    // Floyd-Warshall with strict improvement; an infinite leg never wins
    function automatic void predict_solve();
        logic [DIST_W:0]     span [CELLS];
        logic                none [CELLS];
        logic [VERTEX_W-1:0] via [CELLS];
        logic [DIST_W:0]     detour;
        pair_result_t        r;
        int                  n;
        int                  ij;
        int                  ik;
        int                  kj;
        n = (count_setting == 0) ? 1 :
            (count_setting > MAX_VERTICES) ? MAX_VERTICES : int'(count_setting);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                ij = i * MAX_VERTICES + j;
                span[ij] = (DIST_W + 1)'(edge_len[ij]);
                none[ij] = edge_gone[ij];
                via[ij] = VERTEX_W'(i);
            end
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                begin
                    ik = i * MAX_VERTICES + k;
                    kj = k * MAX_VERTICES + j;
                    ij = i * MAX_VERTICES + j;
                    if (!none[ik] && !none[kj])
                    begin
                        detour = span[ik] + span[kj];
                        if (none[ij] || detour < span[ij])
                        begin
                            span[ij] = detour;
                            none[ij] = 1'b0;
                            via[ij] = via[kj];
                        end
                    end
                end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                ij = i * MAX_VERTICES + j;
                r.src_v = VERTEX_W'(i);
                r.dst_v = VERTEX_W'(j);
                r.length = none[ij] ? '0 : span[ij][DIST_OUT_W-1:0];
                r.unreach = none[ij];
                r.pred = via[ij];
                r.last = (i == n - 1) && (j == n - 1);
                expected_pairs.push_back(r);
            end
    endfunction

    task automatic check_result();
        pair_result_t got;
        pair_result_t want;
        string        bad;
        got = {pair_source, pair_destination, distance, unreachable, predecessor, last_pair};
        if (expected_pairs.size() == 0)
        begin
            report_mismatch($sformatf("result (%0d,%0d) with none expected",
                                      got.src_v, got.dst_v));
            return;
        end
        want = expected_pairs.pop_front();
        bad = "";
        if (got.src_v !== want.src_v) bad = {bad, " pair_source"};
        if (got.dst_v !== want.dst_v) bad = {bad, " pair_destination"};
        if (got.length !== want.length) bad = {bad, " distance"};
        if (got.unreach !== want.unreach) bad = {bad, " unreachable"};
        if (got.pred !== want.pred) bad = {bad, " predecessor"};
        if (got.last !== want.last) bad = {bad, " last_pair"};
        if (bad != "")
            report_mismatch($sformatf(
                {"(%0d,%0d) bad:%s | got d=%0d u=%0d p=%0d l=%0d",
                 " want (%0d,%0d) d=%0d u=%0d p=%0d l=%0d"},
                got.src_v, got.dst_v, bad, got.length, got.unreach, got.pred, got.last,
                want.src_v, want.dst_v, want.length, want.unreach, want.pred, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_edges();
            count_setting = COUNT_W'(VERTEX_COUNT_RESET);
            expected_pairs.delete();
            results_outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                count_setting = cfg_data;
            // results leaving now belong to earlier solves
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
            begin
                case (action)
                    ACT_WRITE:
                    begin
                        edge_len[{from_vertex, to_vertex}] = edge_weight[STORED_W-1:0];
                        edge_gone[{from_vertex, to_vertex}] = no_edge;
                    end
                    ACT_CLEAR: clear_edges();
                    ACT_SOLVE: predict_solve();
                    default: ;
                endcase
            end
            results_outstanding <= expected_pairs.size();
        end
    end

endmodule

>>> tb/all_pairs_shortest_path_tb.sv
module all_pairs_shortest_path_tb;
    import apsp_pkg::*;

    // Action code the block must drop without effect
    localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

    localparam int RANDOM_ITEMS = 75;
    // Quiet cycles after the last result before touching vertex_count
    localparam int DRAIN_CYCLES = 16;
    // Long output hold-off that backs the block up into its input
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic                   clk = 1'b0;
    logic                   rst_n;

    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [ACTION_W-1:0]    action = ACT_WRITE;
    logic [VERTEX_W-1:0]    from_vertex = '0;
    logic [VERTEX_W-1:0]    to_vertex = '0;
    logic [IN_WEIGHT_W-1:0] edge_weight = '0;
    logic                   no_edge = 1'b0;

    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [VERTEX_W-1:0]    pair_source;
    logic [VERTEX_W-1:0]    pair_destination;
    logic [DIST_OUT_W-1:0]  distance;
    logic                   unreachable;
    logic [VERTEX_W-1:0]    predecessor;
    logic                   last_pair;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [COUNT_W-1:0]     cfg_data = '0;

    int mismatch_total;
    int results_outstanding;
    int cycle_count = 0;
    int send_burst = 0;
    int active_vertices = VERTEX_COUNT_RESET;
    int accepted_items = 0;

    all_pairs_shortest_path dut (.*);

    // Watch all three channels, predict every solve and compare each pair
    apsp_path_checker path_check (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Assert reset once and release it on a falling edge
    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one input transaction. Enter at a falling edge; return at the falling
    // edge after acceptance with valid still high, so the caller must follow with
    // another transaction or a drain in the same step.
    task automatic send_request(input logic [ACTION_W-1:0]    act,
                                input logic [VERTEX_W-1:0]    src,
                                input logic [VERTEX_W-1:0]    dst,
                                input logic [IN_WEIGHT_W-1:0] wt,
                                input logic                   absent);
        int gap;
        // Mix random gaps with stretches of back-to-back transactions
        if (send_burst > 0)
        begin
            send_burst--;
            gap = 0;
        end
        else if ($urandom_range(0, 11) == 0)
        begin
            send_burst = $urandom_range(8, 24);
            gap = 0;
        end
        else
            gap = $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        from_vertex <= src;
        to_vertex <= dst;
        edge_weight <= wt;
        no_edge <= absent;
        // Hold the payload until the block stops stalling
        do @(posedge clk); while (!(in_valid && !in_stall));
        @(negedge clk);
        if (act != ACT_IGNORED)
            accepted_items++;
    endtask

    // Drop valid and wait until every predicted pair has come out, then a bit more
    task automatic drain_block();
        in_valid <= 1'b0;
        while (results_outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write vertex_count; call only after drain_block
    task automatic set_vertex_count(input logic [COUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        active_vertices = (value == 0) ? 1 :
                          (value > MAX_VERTICES) ? MAX_VERTICES : int'(value);
    endtask

    // Favor the extremes: zero acts as one, anything above eight as eight
    function automatic logic [COUNT_W-1:0] pick_vertex_count();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2: return COUNT_W'(MAX_VERTICES);
            3: return COUNT_W'(1);
            4: return COUNT_W'($urandom_range(0, 15));
            default: return COUNT_W'($urandom_range(2, 7));
        endcase
    endfunction

    // Small weights make ties and shortcuts likely; the top value stresses the sum width
    function automatic logic [IN_WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 3))
            0: return IN_WEIGHT_W'($urandom_range(0, 15));
            1: return '1;
            2: return IN_WEIGHT_W'($urandom);
            default: return IN_WEIGHT_W'($urandom_range(0, 300));
        endcase
    endfunction

    // One graph: maybe a new vertex_count, maybe a clear, a handful of edges, a solve.
    // Rounds without a register write run straight on, so writes for the next
    // graph queue up behind a solve that is still emitting.
    task automatic random_graph_round();
        int                  edges;
        logic [VERTEX_W-1:0] a;
        logic [VERTEX_W-1:0] b;
        if ($urandom_range(0, 2) == 0)
        begin
            drain_block();
            set_vertex_count(pick_vertex_count());
        end
        if ($urandom_range(0, 1) == 1)
            send_request(ACT_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom),
                         IN_WEIGHT_W'($urandom), 1'($urandom));
        edges = $urandom_range(1, 12);
        repeat (edges)
        begin
            a = VERTEX_W'($urandom_range(0, active_vertices - 1));
            b = VERTEX_W'($urandom_range(0, active_vertices - 1));
            case ($urandom_range(0, 9))
                0: send_request(ACT_IGNORED, a, b, pick_weight(), 1'($urandom));
                // any vertex, including ones the solve will not use
                1: send_request(ACT_WRITE, VERTEX_W'($urandom), VERTEX_W'($urandom),
                                pick_weight(), 1'($urandom));
                default: send_request(ACT_WRITE, a, b, pick_weight(),
                                      $urandom_range(0, 5) == 0);
            endcase
        end
        send_request(ACT_SOLVE, VERTEX_W'($urandom), VERTEX_W'($urandom),
                     IN_WEIGHT_W'($urandom), 1'($urandom));
    endtask

    // Result side: random hold-off per transaction, bursts with none, and a long
    // hold-off now and then that forces the block to stall its input
    initial
    begin : result_sink
        int hold;
        int burst;
        int taken;
        burst = 0;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (taken % 160 == 100)
                hold = LONG_HOLD;
            else if (burst > 0)
            begin
                burst--;
                hold = 0;
            end
            else if ($urandom_range(0, 11) == 0)
            begin
                burst = $urandom_range(8, 40);
                hold = 0;
            end
            else
                hold = $urandom_range(0, 15);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int first_random;
        @(posedge rst_n);
        @(negedge clk);

        // Solve the reset graph: every off-diagonal pair unreachable
        send_request(ACT_SOLVE, 3'd5, 3'd2, 16'hA5A5, 1'b1);
        // Longest possible chain gives the widest distance
        for (int v = 0; v < MAX_VERTICES - 1; v++)
            send_request(ACT_WRITE, VERTEX_W'(v), VERTEX_W'(v + 1), '1, 1'b0);
        // Absent edge with a weight that must be ignored
        send_request(ACT_WRITE, 3'd7, 3'd0, '1, 1'b1);
        // Nonzero self-distance
        send_request(ACT_WRITE, 3'd0, 3'd0, 16'd3, 1'b0);
        // Unused action code must not write this shortcut
        send_request(ACT_IGNORED, 3'd7, 3'd1, 16'd5, 1'b0);
        send_request(ACT_SOLVE, 3'd0, 3'd0, '0, 1'b0);

        // Fresh graph with an equal-length detour (direct path must stay) and a zero weight
        send_request(ACT_CLEAR, 3'd1, 3'd2, 16'd77, 1'b0);
        send_request(ACT_WRITE, 3'd2, 3'd4, 16'd40, 1'b0);
        send_request(ACT_WRITE, 3'd4, 3'd5, 16'd60, 1'b0);
        send_request(ACT_WRITE, 3'd2, 3'd5, 16'd100, 1'b0);
        send_request(ACT_WRITE, 3'd5, 3'd2, 16'd0, 1'b0);
        send_request(ACT_SOLVE, 3'd7, 3'd7, '1, 1'b1);

        // Single vertex
        drain_block();
        set_vertex_count(COUNT_W'(1));
        send_request(ACT_SOLVE, 3'd1, 3'd6, 16'h5A5A, 1'b0);

        // Zero acts as one; the write beyond it is kept for later
        drain_block();
        set_vertex_count('0);
        send_request(ACT_WRITE, 3'd0, 3'd0, 16'd9, 1'b0);
        send_request(ACT_WRITE, 3'd5, 3'd0, 16'd1, 1'b0);
        send_request(ACT_SOLVE, 3'd2, 3'd3, 16'd0, 1'b0);

        // Above the maximum acts as the maximum and picks up that stored edge
        drain_block();
        set_vertex_count('1);
        send_request(ACT_SOLVE, 3'd4, 3'd4, 16'hFFFF, 1'b1);

        first_random = accepted_items;
        while (accepted_items < first_random + RANDOM_ITEMS)
            random_graph_round();

        drain_block();
        if (mismatch_total == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
